>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked every edge outside reset.
`define AST_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked every edge, reset included.
`define AST_CHK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/oqe_pkg.sv
// ----------------------------------------------------------------------------
// oqe_pkg
// Types, widths and helpers shared by the oriented quad expander.
// ----------------------------------------------------------------------------
package oqe_pkg;

  localparam int CW        = 32;           // coordinate width
  localparam int QS_W      = 25;           // quad_size width
  localparam logic [QS_W-1:0] QS_RESET = 25'd52429;
  localparam int UNIT_BITS = 30;           // fraction bits of unit vectors
  localparam int MAG_W     = 32;
  localparam int SQ_W      = 64;
  localparam int LEN_W     = 32;           // isqrt result bits
  localparam int Q_W       = 31;           // quotient bits
  localparam int PROD_W    = 56;           // |unit| * quad_size
  localparam int OFS_W     = 27;           // signed half offset
  localparam int SUM_W     = 35;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef logic [2:0][MAG_W-1:0] mag3_t;

  function automatic coord_t sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sd2147483647);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      sat32 = coord_t'(hi);
    end else if (v < lo) begin
      sat32 = coord_t'(lo);
    end else begin
      sat32 = v[CW-1:0];
    end
  endfunction

endpackage

>>> src/oqe_norm.sv
// ----------------------------------------------------------------------------
// oqe_norm
// Pipelined 3-vector normalizer: squares, sum, bit-per-stage isqrt and
// bit-per-stage restoring division, unit result with 30 fraction bits.
// ----------------------------------------------------------------------------
module oqe_norm #(
  parameter int PW = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  oqe_pkg::vec3_t in_vec,
  input  logic [PW-1:0]  in_pay,
  output logic           out_valid,
  output oqe_pkg::vec3_t out_vec,
  output logic [PW-1:0]  out_pay
);
  import oqe_pkg::*;

  localparam int NSQ  = LEN_W;
  localparam int NDIV = Q_W;

  coord_t in_c [3];
  assign in_c[0] = in_vec.x;
  assign in_c[1] = in_vec.y;
  assign in_c[2] = in_vec.z;

  // stage A: magnitudes
  logic          a_v;
  logic [2:0]    a_neg;
  mag3_t         a_mag;
  logic [PW-1:0] a_pay;

  // stage B: squares
  logic                   b_v;
  logic [2:0]             b_neg;
  mag3_t                  b_mag;
  logic [2:0][SQ_W-1:0]   b_sq;
  logic [PW-1:0]          b_pay;

  // isqrt stages, index 0 holds the radicand
  logic            r_v    [NSQ+1];
  logic [2:0]      r_neg  [NSQ+1];
  mag3_t           r_mag  [NSQ+1];
  logic [33:0]     r_rem  [NSQ+1];
  logic [LEN_W-1:0] r_root [NSQ+1];
  logic [SQ_W-1:0] r_rad  [NSQ+1];
  logic [PW-1:0]   r_pay  [NSQ+1];

  // divide stages, index 0 holds the initial partial remainder
  logic                   d_v    [NDIV+1];
  logic [2:0]             d_neg  [NDIV+1];
  logic                   d_zero [NDIV+1];
  logic [LEN_W-1:0]       d_len  [NDIV+1];
  logic [2:0][32:0]       d_rem  [NDIV+1];
  logic [2:0][Q_W-1:0]    d_q    [NDIV+1];
  logic [2:0][Q_W-1:0]    d_low  [NDIV+1];
  logic [PW-1:0]          d_pay  [NDIV+1];

  coord_t o_c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      r_v[0] <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      r_v[0] <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_c[i][CW-1];
        a_mag[i] <= in_c[i][CW-1] ? MAG_W'(-in_c[i]) : MAG_W'(in_c[i]);
        b_sq[i]  <= {32'b0, a_mag[i]} * {32'b0, a_mag[i]};
      end
      a_pay <= in_pay;
      b_neg <= a_neg;
      b_mag <= a_mag;
      b_pay <= a_pay;
      r_neg[0]  <= b_neg;
      r_mag[0]  <= b_mag;
      r_pay[0]  <= b_pay;
      r_rad[0]  <= b_sq[0] + b_sq[1] + b_sq[2];
      r_rem[0]  <= '0;
      r_root[0] <= '0;
    end
  end

  // one root bit per stage
  for (genvar k = 1; k <= NSQ; k++) begin : g_sqrt
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;
    assign rem_sh = {r_rem[k-1][31:0], r_rad[k-1][SQ_W-1 -: 2]};
    assign trial  = {r_root[k-1], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        r_v[k] <= 1'b0;
      end else if (en) begin
        r_v[k] <= r_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_neg[k]  <= r_neg[k-1];
        r_mag[k]  <= r_mag[k-1];
        r_pay[k]  <= r_pay[k-1];
        r_rem[k]  <= ge ? rem_sh - trial : rem_sh;
        r_root[k] <= {r_root[k-1][LEN_W-2:0], ge};
        r_rad[k]  <= {r_rad[k-1][SQ_W-3:0], 2'b00};
      end
    end
  end

  // dividend = mag * 2^30 + len/2; its top part is already below len
  logic [2:0][SQ_W-1:0] dvd;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd[i] = ({32'b0, r_mag[NSQ][i]} << UNIT_BITS) + {33'b0, r_root[NSQ][LEN_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else if (en) begin
      d_v[0] <= r_v[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_neg[0]  <= r_neg[NSQ];
      d_pay[0]  <= r_pay[NSQ];
      d_len[0]  <= r_root[NSQ];
      d_zero[0] <= r_root[NSQ] == '0;
      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= {1'b0, dvd[i][SQ_W-2:Q_W]};
        d_low[0][i] <= dvd[i][Q_W-1:0];
        d_q[0][i]   <= '0;
      end
    end
  end

  // one quotient bit per stage, three lanes
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [2:0][32:0] sh;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {d_rem[k-1][i][31:0], d_low[k-1][i][Q_W-1]};
        ge[i] = sh[i] >= {1'b0, d_len[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[k] <= 1'b0;
      end else if (en) begin
        d_v[k] <= d_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_neg[k]  <= d_neg[k-1];
        d_pay[k]  <= d_pay[k-1];
        d_len[k]  <= d_len[k-1];
        d_zero[k] <= d_zero[k-1];
        for (int i = 0; i < 3; i++) begin
          d_rem[k][i] <= ge[i] ? sh[i] - {1'b0, d_len[k-1]} : sh[i];
          d_q[k][i]   <= {d_q[k-1][i][Q_W-2:0], ge[i]};
          d_low[k][i] <= {d_low[k-1][i][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pay <= d_pay[NDIV];
      for (int i = 0; i < 3; i++) begin
        if (d_zero[NDIV]) begin
          o_c[i] <= '0;
        end else if (d_neg[NDIV][i]) begin
          o_c[i] <= -$signed({1'b0, d_q[NDIV][i]});
        end else begin
          o_c[i] <= $signed({1'b0, d_q[NDIV][i]});
        end
      end
    end
  end

  assign out_vec = {o_c[0], o_c[1], o_c[2]};

endmodule

>>> src/oriented_quad_expand_core.sv
// ----------------------------------------------------------------------------
// oriented_quad_expand_core
// Expands one particle into the four strip vertices of a square quad laid
// along the particle heading.
// ----------------------------------------------------------------------------
// A particle transfer on s_* yields four vertex transfers on m_* in the order
// front-left, front-right, back-left, back-right; m_tlast marks the fourth.
// The heading and then the side axis go through two pipelined normalizers
// (one isqrt bit and one quotient bit per stage). The output port gives one
// vertex per cycle while m_tready is high, four per particle; the whole pipeline
// holds while the output stage is still emitting corners.
// quad_size is written through cfg_we/cfg_data; the user must write it only
// while no particle is in flight, as the block does not enforce this.
module oriented_quad_expand_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [24:0]  cfg_data,   // quad_size
  input  logic         s_tvalid,
  output logic         s_tready,
  // center_x, center_y, center_z, heading_x, heading_y, heading_z, tint
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vert_x, vert_y, vert_z, vert_color, tex_u, tex_v, 6 pad bits
  output logic [135:0] m_tdata,
  output logic [1:0]   m_tuser,    // corner
  output logic         m_tlast     // last_corner
);
  import oqe_pkg::*;

  localparam int P1_W = 4 * CW;
  localparam int P2_W = 7 * CW;

  logic [QS_W-1:0] quad_size;
  logic            adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_size <= QS_RESET;
    end else if (cfg_we) begin
      quad_size <= cfg_data;
    end
  end

  // forward axis
  vec3_t            head;
  logic             n1_v;
  vec3_t            fwd;
  logic [P1_W-1:0]  n1_pay;

  assign head = {s_tdata[127:96], s_tdata[159:128], s_tdata[191:160]};

  oqe_norm #(.PW(P1_W)) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s_tvalid && s_tready),
    .in_vec   (head),
    .in_pay   ({s_tdata[223:192], s_tdata[95:0]}),
    .out_valid(n1_v),
    .out_vec  (fwd),
    .out_pay  (n1_pay)
  );

  // side axis: fwd x +Z, or fwd x +X when that is zero
  vec3_t           cr_vec;
  logic            n2_v;
  vec3_t           side;
  logic [P2_W-1:0] n2_pay;

  always_comb begin
    if (fwd.x == '0 && fwd.y == '0) begin
      cr_vec = {coord_t'(0), fwd.z, coord_t'(0)};
    end else begin
      cr_vec = {fwd.y, coord_t'(-fwd.x), coord_t'(0)};
    end
  end

  oqe_norm #(.PW(P2_W)) u_norm_side (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (n1_v),
    .in_vec   (cr_vec),
    .in_pay   ({n1_pay, fwd}),
    .out_valid(n2_v),
    .out_vec  (side),
    .out_pay  (n2_pay)
  );

  coord_t u_c [6];
  assign u_c[0] = n2_pay[3*CW-1:2*CW];
  assign u_c[1] = n2_pay[2*CW-1:CW];
  assign u_c[2] = n2_pay[CW-1:0];
  assign u_c[3] = side.x;
  assign u_c[4] = side.y;
  assign u_c[5] = side.z;

  // stage M: |unit| * quad_size
  logic                   m_v;
  logic [5:0]             m_neg;
  logic [5:0][PROD_W-1:0] m_prod;
  logic [P1_W-1:0]        m_pay;

  // stage R: rounded half offsets
  logic                        r_v;
  logic [5:0][OFS_W-1:0]       r_ofs;
  logic [P1_W-1:0]             r_pay;

  // output hold stage
  logic                  h_v;
  logic [1:0]            cnt;
  logic [5:0][OFS_W-1:0] h_ofs;
  logic [P1_W-1:0]       h_pay;
  logic                  load;

  assign load     = h_v && (!m_tvalid || m_tready);
  assign adv      = !h_v || (load && cnt == CORNER_LAST);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      r_v <= 1'b0;
      h_v <= 1'b0;
    end else if (adv) begin
      m_v <= n2_v;
      r_v <= m_v;
      h_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_pay <= n2_pay[P2_W-1:3*CW];
      for (int i = 0; i < 6; i++) begin
        logic [30:0] um;
        logic [PROD_W-1:0] rs;
        um = u_c[i][CW-1] ? 31'(-u_c[i]) : u_c[i][30:0];
        m_neg[i]  <= u_c[i][CW-1];
        m_prod[i] <= PROD_W'({25'b0, um} * {31'b0, quad_size});
        rs = m_prod[i] + (PROD_W'(1) << UNIT_BITS);
        r_ofs[i] <= m_neg[i] ? -{2'b00, rs[PROD_W-1:UNIT_BITS+1]}
                             :  {2'b00, rs[PROD_W-1:UNIT_BITS+1]};
      end
      r_pay <= m_pay;
      h_ofs <= r_ofs;
      h_pay <= r_pay;
    end
  end

  // corner vertex from held offsets
  logic       back;
  logic       right;
  coord_t     vtx [3];

  assign back  = cnt[1];
  assign right = cnt[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SUM_W-1:0] c;
      logic signed [SUM_W-1:0] fo;
      logic signed [SUM_W-1:0] so;
      c  = $signed({{(SUM_W-CW){h_pay[i*CW+CW-1]}}, h_pay[i*CW +: CW]});
      fo = $signed({{(SUM_W-OFS_W){h_ofs[i][OFS_W-1]}}, h_ofs[i]});
      so = $signed({{(SUM_W-OFS_W){h_ofs[i+3][OFS_W-1]}}, h_ofs[i+3]});
      vtx[i] = sat32(c + (back ? -fo : fo) + (right ? so : -so));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      cnt      <= cnt + 2'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'b0, back, right, h_pay[4*CW-1:3*CW], vtx[2], vtx[1], vtx[0]};
      m_tuser <= cnt;
      m_tlast <= cnt == CORNER_LAST;
    end
  end

endmodule

>>> src/oqe_check.sv
// ----------------------------------------------------------------------------
// oqe_check
// Port-level checks for oriented_quad_expand_core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oqe_check (
  input logic         clk,
  input logic         rst,
  input logic         cfg_we,
  input logic [24:0]  cfg_data,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [223:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tlast
);
  import oqe_pkg::*;

  `AST_CHK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "vertex dropped")
  `AST_CHK(a_last_corner, m_tvalid |-> m_tlast == (m_tuser == CORNER_LAST), "tlast mismatch")
  `AST_CHK(a_tex_corner, m_tvalid |-> m_tdata[129:128] == m_tuser, "tex bits mismatch")
  `AST_CHK_ALL(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind oriented_quad_expand_core oqe_check u_oqe_check (.*);

>>> verif/oriented_quad_expand_core_test.sv
// ----------------------------------------------------------------------------
// oriented_quad_expand_core_test
// Drives particles into the quad expander and checks every corner vertex
// against a fixed-point model of the axis normalization and corner offsets.
// ----------------------------------------------------------------------------
module oriented_quad_expand_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import oqe_pkg::*;

  typedef struct {
    logic [1:0]  corner;
    logic [31:0] vx, vy, vz, color;
    logic        u, v, last;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [24:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  oriented_quad_expand_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  vertex_t     pending_verts[$];
  logic [24:0] cur_quad_size;
  int          errors = 0;
  int          particles_sent = 0;
  int          verts_seen = 0;
  bit          idle_on = 1'b1;
  bit          sink_hold = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned val);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv >>= 2;
    while (bitv != 0) begin
      if (val >= res + bitv) begin
        val -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // unit components carry 30 fraction bits
  function automatic void unitize(input longint a[3], output longint o[3]);
    longint unsigned mag[3];
    longint unsigned sq, len, q;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = a[i] < 0 ? -a[i] : a[i];
      sq += mag[i] * mag[i];
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = ((mag[i] << 30) + (len >> 1)) / len;
        o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic longint half_ofs(longint unit_c, logic [24:0] qs);
    longint unsigned m, r;
    m = unit_c < 0 ? -unit_c : unit_c;
    r = (m * qs + (64'd1 << 30)) >> 31;
    return unit_c < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] clamp32(longint val);
    if (val > 64'sd2147483647) return 32'h7FFFFFFF;
    if (val < -64'sd2147483648) return 32'h80000000;
    return val[31:0];
  endfunction

  task automatic expand_particle(logic [223:0] d);
    longint ctr[3], hd[3], fwd[3], cr[3], side[3], fo[3], so[3], acc;
    vertex_t vt;
    for (int i = 0; i < 3; i++) begin
      ctr[i] = longint'($signed(d[32*i +: 32]));
      hd[i]  = longint'($signed(d[32*(i+3) +: 32]));
    end
    unitize(hd, fwd);
    cr[0] = fwd[1]; cr[1] = -fwd[0]; cr[2] = 0;
    if (cr[0] == 0 && cr[1] == 0) begin
      // heading along z: fall back to the x axis cross product
      cr[1] = fwd[2]; cr[2] = -fwd[1];
    end
    unitize(cr, side);
    for (int i = 0; i < 3; i++) begin
      fo[i] = half_ofs(fwd[i], cur_quad_size);
      so[i] = half_ofs(side[i], cur_quad_size);
    end
    for (int k = 0; k < 4; k++) begin
      logic [31:0] pos[3];
      for (int i = 0; i < 3; i++) begin
        acc = ctr[i] + (k[1] ? -fo[i] : fo[i]) + (k[0] ? so[i] : -so[i]);
        pos[i] = clamp32(acc);
      end
      vt.corner = k[1:0];
      vt.vx = pos[0]; vt.vy = pos[1]; vt.vz = pos[2];
      vt.color = d[223:192];
      vt.u = k[0]; vt.v = k[1]; vt.last = (k == 3);
      pending_verts.insert(pending_verts.size(), vt);
    end
  endtask

  // valid and data are set with blocking writes so that one negedge may
  // drop and raise valid between two particles
  task automatic send_particle(logic [223:0] d);
    while (idle_on && $urandom_range(99) < 12) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expand_particle(d);
    particles_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(4000)) - 2000) <<< 16;
      3: return 32'(int'($urandom_range(200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [223:0] rand_particle();
    logic [223:0] d;
    for (int i = 0; i < 7; i++) d[32*i +: 32] = rand_coord();
    d[223:192] = $urandom;
    case ($urandom_range(9))
      0: d[191:96] = '0;
      1: begin d[95+32:96] = '0; d[159:128] = '0; end  // heading along z
      default: ;
    endcase
    return d;
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_verts.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
  endtask

  task automatic write_size(logic [24:0] qs);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= qs;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_quad_size = qs;
  endtask

  function automatic logic [223:0] pack(int cx, int cy, int cz, int hx, int hy, int hz,
                                        logic [31:0] col);
    return {col, 32'(hz), 32'(hy), 32'(hx), 32'(cz), 32'(cy), 32'(cx)};
  endfunction

  task automatic test_directed();
    send_particle(pack(0, 0, 0, 1 << 16, 0, 0, 32'hFF00FF00));
    send_particle(pack(0, 0, 0, 0, 1 << 16, 0, 32'h12345678));
    send_particle(pack(5 << 16, -3 << 16, 7, 0, 0, 0, 32'h0));          // zero heading
    send_particle(pack(0, 0, 0, 0, 0, 1 << 16, 32'hFFFFFFFF));          // along +z
    send_particle(pack(0, 0, 0, 0, 0, -5, 32'hA5A5A5A5));               // along -z
    send_particle(pack(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h5A5A5A5A));
    send_particle(pack(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h0F0F0F0F));
    send_particle(pack(1, -1, 0, 32'h80000000, 1, -1, 32'hF0F0F0F0));
    send_particle(pack(0, 0, 0, 3, 4, 0, 32'h1));
    send_particle(pack(100, 200, 300, -3, -4, 12, 32'h80000000));
  endtask

  task automatic test_sizes();
    logic [24:0] sizes[4] = '{25'd0, 25'h1FFFFFF, 25'd16777216, 25'd1};
    foreach (sizes[j]) begin
      write_size(sizes[j]);
      for (int n = 0; n < 8; n++) send_particle(rand_particle());
      send_particle(pack(32'h7FFFFFF0, 32'h80000010, 0, 1, -1, 1, 32'h33));
    end
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) send_particle(rand_particle());
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        sink_hold = 1'b0;
      end
      for (int n = 0; n < 30; n++) send_particle(rand_particle());
    join
  endtask

  // sink: random stalls except during the back-to-back stretch, held off while sink_hold is set
  always @(negedge clk) begin
    if (rst || sink_hold) m_tready <= 1'b0;
    else m_tready <= !(idle_on && $urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      vertex_t got, want;
      got.vx = m_tdata[31:0]; got.vy = m_tdata[63:32]; got.vz = m_tdata[95:64];
      got.color = m_tdata[127:96]; got.u = m_tdata[128]; got.v = m_tdata[129];
      got.corner = m_tuser; got.last = m_tlast;
      verts_seen++;
      if (pending_verts.size() == 0) begin
        $display("%0t: vertex with none expected: corner %0d x %h", $realtime,
                 got.corner, got.vx);
        errors++;
      end else begin
        want = pending_verts.pop_front();
        if (got.corner !== want.corner) begin
          $display("%0t: corner exp %0d got %0d", $realtime, want.corner, got.corner);
          errors++;
        end
        if (got.vx !== want.vx) begin
          $display("%0t: vert_x exp %h got %h", $realtime, want.vx, got.vx);
          errors++;
        end
        if (got.vy !== want.vy) begin
          $display("%0t: vert_y exp %h got %h", $realtime, want.vy, got.vy);
          errors++;
        end
        if (got.vz !== want.vz) begin
          $display("%0t: vert_z exp %h got %h", $realtime, want.vz, got.vz);
          errors++;
        end
        if (got.color !== want.color) begin
          $display("%0t: color exp %h got %h", $realtime, want.color, got.color);
          errors++;
        end
        if (got.u !== want.u || got.v !== want.v) begin
          $display("%0t: tex uv exp %b%b got %b%b", $realtime, want.u, want.v,
                   got.u, got.v);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: tlast exp %b got %b", $realtime, want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    cur_quad_size = QS_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_sizes();
    write_size(QS_RESET);
    test_backpressure();
    test_random(180);
    idle_on = 1'b0;
    test_random(60);          // back-to-back stretch
    idle_on = 1'b1;
    write_size(25'd3 << 16);
    test_random(120);
    drain();
    if (pending_verts.size() != 0) begin
      $display("%0d vertices never arrived", pending_verts.size());
      errors++;
    end
    $display("Covered %0d particles, %0d vertices, six quad sizes, stalls on both sides.",
             particles_sent, verts_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
